[hw/rtl/permuted_interval_gap_counter_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the permuted interval gap counter
// Concurrent checks clocked on the rising edge, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef PERMUTED_INTERVAL_GAP_COUNTER_TOP_MACROS_SVH
`define PERMUTED_INTERVAL_GAP_COUNTER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Implication checked at every edge out of reset
`define PIGC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst) prop) \
    else $error(msg);

// Condition now implies a consequence in the next cycle
`define PIGC_ASSERT_NEXT(lbl, clk, rst, cond, nxt, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst) (cond) |=> (nxt)) \
    else $error(msg);

`else

`define PIGC_ASSERT(lbl, clk, rst, prop, msg)
`define PIGC_ASSERT_NEXT(lbl, clk, rst, cond, nxt, msg)

`endif

`endif

[hw/rtl/pigc_pkg.sv]
// ----------------------------------------------------------------------------
// pigc_pkg
// Shared widths, operation codes and the command type of the gap counter.
// ----------------------------------------------------------------------------
`default_nettype none

package pigc_pkg;

  localparam int MAX_NODES_DEF = 64;
  localparam int NODE_CNT_W    = 7;
  localparam int SLOT_W        = 6;
  localparam int DIET_W        = 64;
  localparam int TOTAL_W       = 12;
  localparam int OP_W          = 2;
  localparam int CMDQ_DEPTH    = 2;

  localparam logic [NODE_CNT_W-1:0] NODE_CNT_RST = 7'd64;

  localparam logic [OP_W-1:0] OP_LOAD_DIET  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_ORDER = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE    = 2'd2;

  typedef enum logic [1:0] {
    CMD_DIET,
    CMD_ORDER,
    CMD_COMPUTE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [SLOT_W-1:0]   slot;
    logic [DIET_W-1:0]   bits;
    logic [SLOT_W-1:0]   value;
  } cmd_t;

endpackage

`default_nettype wire

[hw/rtl/pigc_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// pigc_cmd_fifo
// Short command queue between the classifying front and the executing back.
// ----------------------------------------------------------------------------
`default_nettype none

`include "permuted_interval_gap_counter_top_macros.svh"

module pigc_cmd_fifo
  import pigc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output cmd_t      head_cmd,
  output logic      empty,
  output logic      full
);

  localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

  cmd_t             mem_r [CMDQ_DEPTH];
  logic [PTR_W-1:0] wptr_r;
  logic [PTR_W-1:0] rptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == CNT_W'(CMDQ_DEPTH));
  assign head_cmd = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : PTR_W'(wptr_r + 1'b1);
      end
      if (pop) begin
        rptr_r <= (rptr_r == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : PTR_W'(rptr_r + 1'b1);
      end
      case ({push, pop})
        2'b10:   cnt_r <= CNT_W'(cnt_r + 1'b1);
        2'b01:   cnt_r <= CNT_W'(cnt_r - 1'b1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  `PIGC_ASSERT(a_no_overflow, clk, rst_n, push |-> !full, "command queue overflow")
  `PIGC_ASSERT(a_no_underflow, clk, rst_n, pop |-> !empty, "command queue underflow")
  `PIGC_ASSERT(a_cnt_bound, clk, rst_n, cnt_r <= CNT_W'(CMDQ_DEPTH), "queue count out of range")

endmodule

`default_nettype wire

[hw/rtl/pigc_front.sv]
// ----------------------------------------------------------------------------
// pigc_front
// Accepts command beats, decodes the operation and drops the ones with no effect.
// ----------------------------------------------------------------------------
`default_nettype none

module pigc_front
  import pigc_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  wire logic              start,
  input  wire logic              q_full,
  input  wire logic [OP_W-1:0]   in_operation,
  input  wire logic [SLOT_W-1:0] in_slot,
  input  wire logic [DIET_W-1:0] in_diet_bits,
  input  wire logic [SLOT_W-1:0] in_order_value,
  output logic                   busy,
  output logic                   push,
  output cmd_t                   push_cmd
);

  logic accept;
  logic slot_ok;
  logic keep;

  assign busy    = q_full;
  assign accept  = start && !q_full;
  assign slot_ok = (int'(in_slot) < MAX_NODES);

  always_comb begin
    push_cmd.slot  = in_slot;
    push_cmd.bits  = in_diet_bits;
    push_cmd.value = in_order_value;
    push_cmd.kind  = CMD_COMPUTE;
    keep           = 1'b0;
    unique case (in_operation)
      OP_LOAD_DIET: begin
        push_cmd.kind = CMD_DIET;
        keep          = slot_ok;
      end
      OP_LOAD_ORDER: begin
        push_cmd.kind = CMD_ORDER;
        keep          = slot_ok;
      end
      OP_COMPUTE: begin
        push_cmd.kind = CMD_COMPUTE;
        keep          = 1'b1;
      end
      // unused code: drop the beat
      default: keep = 1'b0;
    endcase
  end

  assign push = accept && keep;

endmodule

`default_nettype wire

[hw/rtl/pigc_back.sv]
// ----------------------------------------------------------------------------
// pigc_back
// Holds the diet rows and order lanes, runs loads and the gap-count pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

`include "permuted_interval_gap_counter_top_macros.svh"

module pigc_back
  import pigc_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [NODE_CNT_W-1:0] cfg_wr_data,
  input  wire logic                  q_empty,
  input  wire cmd_t                  q_cmd,
  output logic                       pop,
  output logic                       out_valid,
  output logic [TOTAL_W-1:0]         out_total_gaps
);

  localparam int IDX_W = $clog2(MAX_NODES);
  localparam int CNT_W = $clog2(MAX_NODES + 1);
  localparam int NGRP  = (MAX_NODES + 7) / 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        row_cnt_r, row_cnt_nxt;
  logic [TOTAL_W-1:0]      total_r, total_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [TOTAL_W-1:0]      out_total_r, out_total_nxt;
  logic [NODE_CNT_W-1:0]   node_count_r;
  logic [CNT_W-1:0]        n_eff;

  logic                    rd_en;
  logic                    diet_we;
  logic                    order_we;

  logic [MAX_NODES-1:0]    diet_mem [MAX_NODES];
  logic [SLOT_W-1:0]       order_r  [MAX_NODES];

  // pipeline: read, gather, isolate, encode, accumulate
  logic                    s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r;
  logic [MAX_NODES-1:0]    rd_data_r;
  logic [MAX_NODES-1:0]    p_r, p_nxt;
  logic                    s2_multi_r, multi_nxt;
  logic [MAX_NODES-1:0]    lo_oh_r, hi_oh_r, lo_oh_nxt, hi_oh_nxt;
  logic [3:0]              grp_cnt_r [NGRP];
  logic [3:0]              grp_cnt_nxt [NGRP];
  logic                    s3_multi_r, s3_nz_r;
  logic [IDX_W-1:0]        s4_first_r, s4_last_r, first_nxt, last_nxt;
  logic [CNT_W-1:0]        s4_pop_r, pop_nxt;
  logic                    s4_multi_r, s4_nz_r;
  logic [CNT_W-1:0]        gap;

  assign n_eff = (int'(node_count_r) > MAX_NODES) ? CNT_W'(MAX_NODES)
                                                  : CNT_W'(node_count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_CNT_RST;
    end else if (cfg_wr_en) begin
      node_count_r <= cfg_wr_data;
    end
  end

  // diet row memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (diet_we) begin
      diet_mem[q_cmd.slot[IDX_W-1:0]] <= q_cmd.bits[MAX_NODES-1:0];
    end
    if (rd_en) begin
      rd_data_r <= diet_mem[row_cnt_r[IDX_W-1:0]];
    end
  end

  // order lanes: each lane feeds its own gather mux
  always_ff @(posedge clk) begin
    if (order_we) begin
      order_r[q_cmd.slot[IDX_W-1:0]] <= q_cmd.value;
    end
  end

  // gather the row through the ordering; mask both sides to the nodes in use
  always_comb begin
    logic [MAX_NODES-1:0] masked;
    masked = '0;
    p_nxt  = '0;
    for (int j = 0; j < MAX_NODES; j++) begin
      masked[j] = rd_data_r[j] && (j < int'(n_eff));
    end
    for (int i = 0; i < MAX_NODES; i++) begin
      if ((i < int'(n_eff)) && (int'(order_r[i]) < int'(n_eff))) begin
        p_nxt[i] = rd_data_r[order_r[i][IDX_W-1:0]];
      end
    end
    multi_nxt = |(masked & (masked - MAX_NODES'(1)));
  end

  // isolate lowest and highest set positions, count ones per byte
  always_comb begin
    logic [MAX_NODES-1:0] rev;
    logic [MAX_NODES-1:0] rev_oh;
    for (int i = 0; i < MAX_NODES; i++) begin
      rev[i] = p_r[MAX_NODES-1-i];
    end
    lo_oh_nxt = p_r & (~p_r + MAX_NODES'(1));
    rev_oh    = rev & (~rev + MAX_NODES'(1));
    for (int i = 0; i < MAX_NODES; i++) begin
      hi_oh_nxt[i] = rev_oh[MAX_NODES-1-i];
    end
    for (int g = 0; g < NGRP; g++) begin
      grp_cnt_nxt[g] = '0;
      for (int b = 0; b < 8; b++) begin
        if ((g * 8 + b) < MAX_NODES) begin
          grp_cnt_nxt[g] = grp_cnt_nxt[g] + 4'(p_r[(g * 8 + b) % MAX_NODES]);
        end
      end
    end
  end

  // encode the one-hot positions, add up the byte counts
  always_comb begin
    first_nxt = '0;
    last_nxt  = '0;
    pop_nxt   = '0;
    for (int i = 0; i < MAX_NODES; i++) begin
      if (lo_oh_r[i]) first_nxt = first_nxt | IDX_W'(i);
      if (hi_oh_r[i]) last_nxt  = last_nxt  | IDX_W'(i);
    end
    for (int g = 0; g < NGRP; g++) begin
      pop_nxt = CNT_W'(pop_nxt + CNT_W'(grp_cnt_r[g]));
    end
  end

  // clear positions strictly inside the span
  assign gap = CNT_W'(CNT_W'(s4_last_r) - CNT_W'(s4_first_r) + CNT_W'(1) - s4_pop_r);

  always_ff @(posedge clk) begin
    p_r        <= p_nxt;
    s2_multi_r <= multi_nxt;
    lo_oh_r    <= lo_oh_nxt;
    hi_oh_r    <= hi_oh_nxt;
    grp_cnt_r  <= grp_cnt_nxt;
    s3_multi_r <= s2_multi_r;
    s3_nz_r    <= |p_r;
    s4_first_r <= first_nxt;
    s4_last_r  <= last_nxt;
    s4_pop_r   <= pop_nxt;
    s4_multi_r <= s3_multi_r;
    s4_nz_r    <= s3_nz_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= rd_en;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    row_cnt_nxt   = row_cnt_r;
    total_nxt     = total_r;
    out_valid_nxt = 1'b0;
    out_total_nxt = out_total_r;
    pop           = 1'b0;
    rd_en         = 1'b0;
    diet_we       = 1'b0;
    order_we      = 1'b0;
    if (s4_vld_r && s4_multi_r && s4_nz_r) begin
      total_nxt = TOTAL_W'(total_r + TOTAL_W'(gap));
    end
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          unique case (q_cmd.kind)
            CMD_DIET:  diet_we  = 1'b1;
            CMD_ORDER: order_we = 1'b1;
            CMD_COMPUTE: begin
              total_nxt   = '0;
              row_cnt_nxt = '0;
              state_nxt   = (n_eff == '0) ? ST_DRAIN : ST_RUN;
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        rd_en       = 1'b1;
        row_cnt_nxt = CNT_W'(row_cnt_r + 1'b1);
        if (CNT_W'(row_cnt_r + 1'b1) == n_eff) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // hold until the last row has been accumulated
        if (!(s1_vld_r || s2_vld_r || s3_vld_r || s4_vld_r)) begin
          out_valid_nxt = 1'b1;
          out_total_nxt = total_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      row_cnt_r   <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      out_total_r <= '0;
    end else begin
      state_r     <= state_nxt;
      row_cnt_r   <= row_cnt_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      out_total_r <= out_total_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_total_gaps = out_total_r;

  `PIGC_ASSERT(a_out_from_drain, clk, rst_n, out_valid_r |-> $past(state_r == ST_DRAIN), "result not from drain")
  `PIGC_ASSERT(a_run_in_range, clk, rst_n, (state_r == ST_RUN) |-> (row_cnt_r < n_eff), "row index past node count")
  `PIGC_ASSERT(a_idle_pipe_empty, clk, rst_n, (state_r == ST_IDLE) |-> !(s1_vld_r || s2_vld_r || s3_vld_r || s4_vld_r), "pipeline busy while idle")
  `PIGC_ASSERT_NEXT(a_single_strobe, clk, rst_n, out_valid_r, !out_valid_r, "result strobe held")

endmodule

`default_nettype wire

[hw/rtl/permuted_interval_gap_counter_top.sv]
// ----------------------------------------------------------------------------
// permuted_interval_gap_counter_top
// Loads diet rows and a position ordering, then totals the interior gaps.
//
//   channel  handshake               payload
//   in       start & !busy           in_operation, in_slot, in_diet_bits,
//                                    in_order_value
//   out      out_valid, one cycle    out_total_gaps
//   cfg      cfg_wr_en               cfg_wr_data (node_count)
//
// A load writes its store as it is popped in the back end; a compute reads n rows, n being
// node_count capped at MAX_NODES (none when n is zero), one diet row read
// from the row memory per cycle through a five-stage gather/count pipeline.
// Loads queued behind a compute wait for it.
// busy rises when the two-entry command queue is full. The result strobe
// cannot be stalled. Reset is synchronous; the stores are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module permuted_interval_gap_counter_top
  import pigc_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [OP_W-1:0]       in_operation,
  input  wire logic [SLOT_W-1:0]     in_slot,
  input  wire logic [DIET_W-1:0]     in_diet_bits,
  input  wire logic [SLOT_W-1:0]     in_order_value,
  output logic                       out_valid,
  output logic [TOTAL_W-1:0]         out_total_gaps,
  input  wire logic                  cfg_wr_en,
  input  wire logic [NODE_CNT_W-1:0] cfg_wr_data
);

  logic push;
  cmd_t push_cmd;
  logic pop;
  cmd_t head_cmd;
  logic q_empty;
  logic q_full;

  pigc_front #(
    .MAX_NODES(MAX_NODES)
  ) u_front (
    .start         (start),
    .q_full        (q_full),
    .in_operation  (in_operation),
    .in_slot       (in_slot),
    .in_diet_bits  (in_diet_bits),
    .in_order_value(in_order_value),
    .busy          (busy),
    .push          (push),
    .push_cmd      (push_cmd)
  );

  pigc_cmd_fifo u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .head_cmd(head_cmd),
    .empty   (q_empty),
    .full    (q_full)
  );

  pigc_back #(
    .MAX_NODES(MAX_NODES)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .q_empty       (q_empty),
    .q_cmd         (head_cmd),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_total_gaps(out_total_gaps)
  );

endmodule

`default_nettype wire
